@@ rtl/core/kwfr_pkg.sv @@
`default_nettype none

package kwfr_pkg;

    localparam int unsigned KIND_W     = 2;
    localparam int unsigned AMINO_W    = 5;
    localparam int unsigned START_W    = 32;
    localparam int unsigned OUT_PFX_W  = 26;
    localparam int unsigned OUT_SFX_W  = 60;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 208;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_AMINO   = 2'd0;
    localparam t_kind KIND_INVALID = 2'd1;
    localparam t_kind KIND_END     = 2'd2;

    typedef struct packed {
        t_kind              kind;
        logic [AMINO_W-1:0] amino;
    } t_item;

    // packed so that start_position lands in the lowest bits
    typedef struct packed {
        logic [OUT_SFX_W-1:0] rev_suffix;
        logic [OUT_PFX_W-1:0] rev_prefix;
        logic [OUT_SFX_W-1:0] fwd_suffix;
        logic [OUT_PFX_W-1:0] fwd_prefix;
        logic [START_W-1:0]   start_position;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result result;
    } t_core_out;

    function automatic logic [63:0] pow_u64(input int unsigned base, input int unsigned n);
        logic [63:0] p;
        p = 64'd1;
        for (int unsigned i = 0; i < n; i++) begin
            p = p * 64'(base);
        end
        return p;
    endfunction

    // bits needed to hold values up to v, at least one
    function automatic int unsigned bits_for(input logic [63:0] v);
        int unsigned b;
        b = 1;
        for (int unsigned i = 1; i < 64; i++) begin
            if (v[i]) begin
                b = i + 1;
            end
        end
        return b;
    endfunction

    function automatic int unsigned trailing_zeros(input int unsigned v);
        int unsigned t;
        logic        found;
        t     = 0;
        found = 1'b0;
        for (int unsigned i = 0; i < 32; i++) begin
            if (!found) begin
                if (((v >> i) & 1) != 0) begin
                    found = 1'b1;
                end else begin
                    t = t + 1;
                end
            end
        end
        return t;
    endfunction

    // inverse of an odd number modulo 2^64, for exact division
    function automatic logic [63:0] odd_inverse(input logic [63:0] m);
        logic [63:0] x;
        x = m;
        for (int i = 0; i < 6; i++) begin
            x = x * (64'd2 - m * x);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/kwfr_in_stage.sv @@
`default_nettype none

module kwfr_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire kwfr_pkg::t_item i_item,
    input  wire logic           i_advance,
    output logic                o_valid,
    output kwfr_pkg::t_item     o_item
);
    import kwfr_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_s_tready = i_rst_n && (!r_valid || i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_advance) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ rtl/core/kwfr_word_core.sv @@
`default_nettype none

module kwfr_word_core #(
    parameter int unsigned ALPHABET_SIZE = 20,
    parameter int unsigned SYMBOL_BITS   = 5,
    parameter int unsigned PREFIX_DIGITS = 6,
    parameter int unsigned SUFFIX_DIGITS = 12,
    parameter int unsigned POSITION_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire kwfr_pkg::t_item  i_item,
    output kwfr_pkg::t_core_out   o_core
);
    import kwfr_pkg::*;

    localparam int unsigned WORD_LEN  = PREFIX_DIGITS + SUFFIX_DIGITS;
    localparam int unsigned RUN_W     = $clog2(WORD_LEN + 1);
    localparam logic [63:0] SPAN      = pow_u64(ALPHABET_SIZE, PREFIX_DIGITS);
    localparam logic [63:0] HIGH      = pow_u64(ALPHABET_SIZE, PREFIX_DIGITS - 1);
    localparam int unsigned PW        = bits_for(SPAN - 64'd1);
    localparam int unsigned TZ        = trailing_zeros(ALPHABET_SIZE);
    localparam logic [63:0] INV       = odd_inverse(64'(ALPHABET_SIZE >> TZ));
    localparam int unsigned DW        = PREFIX_DIGITS * SYMBOL_BITS;
    localparam int unsigned SW        = SUFFIX_DIGITS * SYMBOL_BITS;
    localparam int unsigned SUB_W     = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;
    localparam int unsigned CODE_MASK = (1 << SYMBOL_BITS) - 1;

    localparam logic [PW-1:0]            HIGH_C  = PW'(HIGH);
    localparam logic [PW-1:0]            ALPH_C  = PW'(ALPHABET_SIZE);
    localparam logic [PW-1:0]            INV_C   = PW'(INV);
    localparam logic [RUN_W-1:0]         WL_C    = RUN_W'(WORD_LEN);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [RUN_W-1:0]         r_run, n_run;
    logic [PW-1:0]            r_fp, n_fp, r_rp, n_rp;
    logic [SW-1:0]            r_fs, n_fs, r_rs, n_rs;
    logic [DW-1:0]            r_fd, n_fd, r_rd, n_rd;

    logic                   is_end;
    logic                   is_amino;
    logic                   emit;
    logic [SYMBOL_BITS-1:0] code;
    logic [SYMBOL_BITS-1:0] fwd_top;
    logic [SYMBOL_BITS-1:0] fwd_old;
    logic [SYMBOL_BITS-1:0] rev_low;
    logic [PW-1:0]          fwd_base;
    logic [PW-1:0]          fwd_next;
    logic [PW-1:0]          rev_diff;
    logic [PW-1:0]          rev_quot;
    logic [PW-1:0]          rev_next;
    logic [SUB_W-1:0]       start_full;

    assign code    = i_item.amino[SYMBOL_BITS-1:0];
    assign fwd_top = r_fs[SW-1 -: SYMBOL_BITS];
    assign fwd_old = r_fd[DW-1 -: SYMBOL_BITS];
    assign rev_low = r_rd[SYMBOL_BITS-1:0];

    // forward: drop the oldest digit, scale, add the digit moved up from the suffix
    assign fwd_base = r_fp - PW'(PW'(fwd_old) * HIGH_C);
    assign fwd_next = PW'(fwd_base * ALPH_C) + PW'(fwd_top);

    // reverse: remove the lowest digit, exact divide by the alphabet size
    assign rev_diff = r_rp - PW'(rev_low);
    assign rev_quot = PW'((rev_diff >> TZ) * INV_C);
    assign rev_next = rev_quot + PW'(PW'(code) * HIGH_C);

    assign is_end   = (i_item.kind == KIND_END);
    assign is_amino = (i_item.kind == KIND_AMINO)
                   && ({1'b0, i_item.amino} < 6'(ALPHABET_SIZE))
                   && ({1'b0, i_item.amino} <= 6'(CODE_MASK));

    always_comb begin
        n_pos = r_pos;
        n_run = r_run;
        n_fp  = r_fp;
        n_fs  = r_fs;
        n_fd  = r_fd;
        n_rp  = r_rp;
        n_rs  = r_rs;
        n_rd  = r_rd;
        emit  = 1'b0;
        if (is_end) begin
            n_pos = '0;
            n_run = '0;
        end else begin
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
            if (!is_amino) begin
                n_run = '0;
            end else begin
                n_fp = fwd_next;
                n_fs = (r_fs << SYMBOL_BITS) | SW'(code);
                n_fd = (r_fd << SYMBOL_BITS) | DW'(fwd_top);
                n_rp = rev_next;
                n_rs = (r_rs >> SYMBOL_BITS) | (SW'(rev_low) << (SW - SYMBOL_BITS));
                n_rd = (r_rd >> SYMBOL_BITS) | (DW'(code) << (DW - SYMBOL_BITS));
                if (r_run < WL_C) begin
                    n_run = r_run + 1'b1;
                end
                emit = (n_run == WL_C);
            end
        end
    end

    assign start_full = SUB_W'(n_pos) - SUB_W'(WORD_LEN);

    always_comb begin
        o_core.emit                  = emit;
        o_core.result.start_position = start_full[START_W-1:0];
        o_core.result.fwd_prefix     = OUT_PFX_W'(n_fp);
        o_core.result.fwd_suffix     = OUT_SFX_W'(n_fs);
        o_core.result.rev_prefix     = OUT_PFX_W'(n_rp);
        o_core.result.rev_suffix     = OUT_SFX_W'(n_rs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_run <= '0;
            r_fp  <= '0;
            r_fs  <= '0;
            r_fd  <= '0;
            r_rp  <= '0;
            r_rs  <= '0;
            r_rd  <= '0;
        end else if (i_fire) begin
            r_pos <= n_pos;
            r_run <= n_run;
            r_fp  <= n_fp;
            r_fs  <= n_fs;
            r_fd  <= n_fd;
            r_rp  <= n_rp;
            r_rs  <= n_rs;
            r_rd  <= n_rd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/kwfr_out_stage.sv @@
`default_nettype none

module kwfr_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire kwfr_pkg::t_core_out i_core,
    output logic                     o_advance,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output kwfr_pkg::t_result        o_result
);
    import kwfr_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    load;

    // an item without a result moves on even while the output holds
    assign o_advance = i_in_valid && (!i_core.emit || !r_valid || i_m_tready);
    assign load      = o_advance && i_core.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_core.result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

endmodule

`default_nettype wire

@@ rtl/core/kmer_word_forward_reverse_packer.sv @@
`default_nettype none
// channel  | dir | payload
// ---------+-----+--------------------------------------------------------------
// s_axis   | in  | tdata: amino [4:0], zero [7:5]; tuser: kind [1:0]
// m_axis   | out | tdata: start_position, fwd_prefix, fwd_suffix, rev_prefix,
//          |     |        rev_suffix, zero pad [207:204]
//
// One symbol per cycle unless stalled; result register loads from the input stage.
// Rate is set by the combinational word update between input and result registers.
// Synchronous active-low reset clears position, run, words and both valids.
// A stalled result blocks only symbols that produce a result; others pass.

module kmer_word_forward_reverse_packer #(
    parameter int unsigned ALPHABET_SIZE = 20,
    parameter int unsigned SYMBOL_BITS   = 5,
    parameter int unsigned PREFIX_DIGITS = 6,
    parameter int unsigned SUFFIX_DIGITS = 12,
    parameter int unsigned POSITION_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // amino [4:0], zero [7:5]
    input  wire logic [kwfr_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // kind [1:0]
    input  wire logic [kwfr_pkg::KIND_W-1:0]       i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // start_position [31:0], fwd_prefix [57:32], fwd_suffix [117:58],
    // rev_prefix [143:118], rev_suffix [203:144], zero [207:204]
    output logic [kwfr_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata
);
    import kwfr_pkg::*;

    t_item     in_item;
    t_item     stage_item;
    logic      stage_valid;
    logic      advance;
    t_core_out core;
    t_result   result;

    assign in_item.kind  = i_s_axis_tuser;
    assign in_item.amino = i_s_axis_tdata[AMINO_W-1:0];

    kwfr_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_item     (in_item),
        .i_advance  (advance),
        .o_valid    (stage_valid),
        .o_item     (stage_item)
    );

    kwfr_word_core #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .SYMBOL_BITS   (SYMBOL_BITS),
        .PREFIX_DIGITS (PREFIX_DIGITS),
        .SUFFIX_DIGITS (SUFFIX_DIGITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (stage_item),
        .o_core  (core)
    );

    kwfr_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (stage_valid),
        .i_core     (core),
        .o_advance  (advance),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_result   (result)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - $bits(t_result))'(0), result};

endmodule

`default_nettype wire

@@ rtl/core/kwfr_checker.sv @@
`default_nettype none

module kwfr_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic [7:0]   i_s_axis_tdata,
    input wire logic [1:0]   i_s_axis_tuser,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [207:0] o_m_axis_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready, 2))
        else $error("result without a symbol two cycles earlier");

    a_block_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input blocked while output free");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[207:204] == 4'd0)
        else $error("tdata padding not zero");

endmodule

bind kmer_word_forward_reverse_packer kwfr_checker u_kwfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
